FILE: rtl/ebs_pkg.sv
// Package for the eyelid blink sequencer.
// Holds phase, op and progress-kind codes, register indexes and the job word type.
// No dependencies.
package ebs_pkg;

	localparam int TIME_W      = 32;
	localparam int DUR_W       = 16;
	localparam int PROG_W      = 17;
	localparam int CFG_INDEX_W = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PROG_W-1:0] Q16_ONE = PROG_W'(65536);

	localparam logic [CFG_INDEX_W-1:0] REG_CLOSING_TIME = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_TIME  = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_OPENING_TIME = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_GAP  = CFG_INDEX_W'(3);

	localparam logic [DUR_W-1:0] CLOSING_TIME_RST = DUR_W'(80);
	localparam logic [DUR_W-1:0] CLOSED_TIME_RST  = DUR_W'(60);
	localparam logic [DUR_W-1:0] OPENING_TIME_RST = DUR_W'(120);
	localparam logic [DUR_W-1:0] MINIMUM_GAP_RST  = DUR_W'(1000);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CLOSING = 2'd1,
		PH_CLOSED  = 2'd2,
		PH_OPENING = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_TRIGGER    = 2'd1,
		OP_SOFT_RESET = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PK_ZERO = 2'd0,
		PK_FULL = 2'd1,
		PK_DIV  = 2'd2
	} prog_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} back_state_t;

	typedef struct packed {
		phase_t             phase;
		logic               started;
		prog_kind_t         kind;
		logic [DUR_W-1:0]   num;
		logic [DUR_W-1:0]   den;
	} ebs_job_t;

endpackage

FILE: rtl/ebs_front.sv
// Front end of the eyelid blink sequencer: configuration registers and phase state.
// Accepts words, steps the phase machine and pushes one progress job per word.
// Depends on ebs_pkg.
module ebs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [ebs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ebs_pkg::DUR_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [2*ebs_pkg::TIME_W-1:0]      s_tdata,
	input  logic [1:0]                        s_tuser,
	input  logic                              q_full,
	output logic                              q_push,
	output ebs_pkg::ebs_job_t                 q_job
);

	logic [ebs_pkg::DUR_W-1:0]  closing_time_q, closed_time_q, opening_time_q, minimum_gap_q;
	ebs_pkg::phase_t            phase_q, phase_n;
	logic [ebs_pkg::TIME_W-1:0] entry_q, entry_n, last_end_q, last_end_n;
	logic                       armed_q, armed_n;
	logic [ebs_pkg::TIME_W-1:0] now_time, auto_interval, elapsed, since_end, elapsed_new;
	logic [ebs_pkg::DUR_W-1:0]  den;
	logic                       entered, accept;

	assign now_time      = s_tdata[ebs_pkg::TIME_W-1:0];
	assign auto_interval = s_tdata[2*ebs_pkg::TIME_W-1:ebs_pkg::TIME_W];
	assign s_tready      = !q_full;
	assign accept        = s_tvalid && s_tready;
	assign elapsed       = now_time - entry_q;
	assign since_end     = now_time - last_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_time_q <= ebs_pkg::CLOSING_TIME_RST;
			closed_time_q  <= ebs_pkg::CLOSED_TIME_RST;
			opening_time_q <= ebs_pkg::OPENING_TIME_RST;
			minimum_gap_q  <= ebs_pkg::MINIMUM_GAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ebs_pkg::REG_CLOSING_TIME: closing_time_q <= cfg_data;
				ebs_pkg::REG_CLOSED_TIME:  closed_time_q  <= cfg_data;
				ebs_pkg::REG_OPENING_TIME: opening_time_q <= cfg_data;
				ebs_pkg::REG_MINIMUM_GAP:  minimum_gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n    = phase_q;
		last_end_n = last_end_q;
		armed_n    = armed_q;
		entered    = 1'b0;
		entry_n    = entry_q;
		case (s_tuser)
			ebs_pkg::OP_TICK: begin
				unique case (phase_q)
					ebs_pkg::PH_IDLE: begin
						if (!armed_q) begin
							armed_n    = 1'b1;
							last_end_n = now_time;
						end else if (since_end >= {16'd0, minimum_gap_q} &&
						             since_end >= auto_interval) begin
							phase_n = ebs_pkg::PH_CLOSING;
							entered = 1'b1;
						end
					end
					ebs_pkg::PH_CLOSING: begin
						if (elapsed >= {16'd0, closing_time_q}) begin
							phase_n = ebs_pkg::PH_CLOSED;
							entered = 1'b1;
						end
					end
					ebs_pkg::PH_CLOSED: begin
						if (elapsed >= {16'd0, closed_time_q}) begin
							phase_n = ebs_pkg::PH_OPENING;
							entered = 1'b1;
						end
					end
					ebs_pkg::PH_OPENING: begin
						if (elapsed >= {16'd0, opening_time_q}) begin
							phase_n    = ebs_pkg::PH_IDLE;
							last_end_n = now_time;
						end
					end
				endcase
			end
			ebs_pkg::OP_TRIGGER: begin
				if (phase_q == ebs_pkg::PH_IDLE) begin
					phase_n = ebs_pkg::PH_CLOSING;
					entered = 1'b1;
				end
			end
			ebs_pkg::OP_SOFT_RESET: begin
				phase_n    = ebs_pkg::PH_IDLE;
				last_end_n = '0;
				armed_n    = 1'b0;
				entry_n    = '0;
			end
			default: ;
		endcase
		if (entered) begin
			entry_n = now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ebs_pkg::PH_IDLE;
			entry_q    <= '0;
			last_end_q <= '0;
			armed_q    <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			entry_q    <= entry_n;
			last_end_q <= last_end_n;
			armed_q    <= armed_n;
		end
	end

	assign elapsed_new = now_time - entry_n;
	assign den = (phase_n == ebs_pkg::PH_CLOSING) ? closing_time_q : opening_time_q;

	always_comb begin
		q_job.phase   = phase_n;
		q_job.started = (phase_q == ebs_pkg::PH_IDLE) && (phase_n == ebs_pkg::PH_CLOSING);
		q_job.num     = elapsed_new[ebs_pkg::DUR_W-1:0];
		q_job.den     = den;
		if (phase_n == ebs_pkg::PH_IDLE || phase_n == ebs_pkg::PH_CLOSED) begin
			q_job.kind = ebs_pkg::PK_ZERO;
		end else if (elapsed_new >= {16'd0, den}) begin
			q_job.kind = ebs_pkg::PK_FULL;
		end else begin
			q_job.kind = ebs_pkg::PK_DIV;
		end
	end

	assign q_push = accept;

endmodule

FILE: rtl/ebs_queue.sv
// Job queue between front and back end of the eyelid blink sequencer.
// Small register FIFO of ebs_job_t words. Depends on ebs_pkg.
module ebs_queue #(
	parameter int DEPTH = ebs_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ebs_pkg::ebs_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output ebs_pkg::ebs_job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ebs_pkg::ebs_job_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/ebs_back.sv
// Back end of the eyelid blink sequencer: bit-serial Q16 progress divider
// and the output register of the result stream. Depends on ebs_pkg.
module ebs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  ebs_pkg::ebs_job_t     q_job,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata
);

	localparam int DW = ebs_pkg::DUR_W;
	localparam int CNT_W = $clog2(DW);

	ebs_pkg::back_state_t     state_q, state_n;
	logic [DW-1:0]            rem_q, quot_q, den_q, rem_nxt;
	logic [DW:0]              rem2;
	logic                     ge;
	logic [CNT_W-1:0]         cnt_q;
	ebs_pkg::phase_t          phase_q, out_phase_q;
	logic                     started_q, out_started_q, out_valid_q;
	logic [ebs_pkg::PROG_W-1:0] prog_q, out_prog_q;
	logic                     load_out;

	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, den_q};
	assign rem_nxt = ge ? DW'(rem2 - {1'b0, den_q}) : rem2[DW-1:0];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ebs_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_n = (q_job.kind == ebs_pkg::PK_DIV) ? ebs_pkg::BK_DIV : ebs_pkg::BK_DONE;
				end
			end
			ebs_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					state_n = ebs_pkg::BK_DONE;
				end
			end
			ebs_pkg::BK_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_n = ebs_pkg::BK_IDLE;
				end
			end
			default: state_n = ebs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == ebs_pkg::BK_IDLE) && q_valid;
		load_out = (state_q == ebs_pkg::BK_DONE) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ebs_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ebs_pkg::BK_IDLE: begin
				phase_q   <= q_job.phase;
				started_q <= q_job.started;
				den_q     <= q_job.den;
				rem_q     <= q_job.num;
				quot_q    <= '0;
				cnt_q     <= CNT_W'(DW - 1);
				prog_q    <= (q_job.kind == ebs_pkg::PK_FULL) ? ebs_pkg::Q16_ONE : '0;
			end
			ebs_pkg::BK_DIV: begin
				rem_q  <= rem_nxt;
				quot_q <= {quot_q[DW-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					prog_q <= {1'b0, quot_q[DW-2:0], ge};
				end
			end
			default: ;
		endcase
		if (load_out) begin
			out_phase_q   <= phase_q;
			out_prog_q    <= prog_q;
			out_started_q <= started_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_started_q, out_prog_q, out_phase_q};

endmodule

FILE: rtl/eyelid_blink_sequencer_core.sv
// Top level of the eyelid blink sequencer.
// Instantiates ebs_front, ebs_queue and ebs_back; depends on ebs_pkg.
//
// Each input word (tick, trigger or soft reset with a millisecond timestamp) steps
// the blink phase machine in the front end in the cycle it is accepted and yields
// exactly one result word: the phase after the step, the Q16 closing or opening
// progress at that timestamp, and a flag for a blink that just started. The front
// end takes one word per cycle while the job queue has room. In the back end a
// result whose progress needs a quotient passes BK_IDLE, the bit-serial divider
// BK_DIV and BK_DONE; other results skip BK_DIV. Jobs are taken one at a time,
// so the divider sets the sustained rate. Configuration writes are always accepted
// and take effect on the next word; write them while no word is in flight.
module eyelid_blink_sequencer_core #(
	parameter int QUEUE_DEPTH = ebs_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ebs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ebs_pkg::DUR_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,  // now_time[31:0], auto_interval[63:32]
	input  logic [1:0]                      s_tuser,  // op[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata   // phase[1:0], progress_q16[18:2],
	                                                  // blink_started[19], zero[23:20]
);

	ebs_pkg::ebs_job_t push_job, pop_job;
	logic              q_push, q_full, q_pop, q_valid;

	assign cfg_ready = 1'b1;

	ebs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	ebs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_job  (pop_job)
	);

	ebs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[18:2] <= ebs_pkg::Q16_ONE)
		else $error("progress above 1.0");

	a_prog_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ebs_pkg::PH_IDLE || m_tdata[1:0] == ebs_pkg::PH_CLOSED)
		|-> m_tdata[18:2] == '0)
		else $error("progress nonzero in idle or closed");

	a_start_closing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> m_tdata[1:0] == ebs_pkg::PH_CLOSING)
		else $error("blink start outside closing");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

endmodule
